// File: rtl/record_assembly_ring_fifo_macros.svh
// ----------------------------------------------------------------------------
// Record assembly ring FIFO assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RECORD_ASSEMBLY_RING_FIFO_MACROS_SVH
`define RECORD_ASSEMBLY_RING_FIFO_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, quiet during reset.
`define RAF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, quiet during reset.
`define RAF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RAF_ASSERT_NOW(lbl, ante, cons, msg)
`define RAF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/raf_pkg.sv
// ----------------------------------------------------------------------------
// Record assembly ring FIFO package
// Shared constants, operation and status codes, payload and control types.
// ----------------------------------------------------------------------------
package raf_pkg;

	// Ring geometry.
	localparam int DEPTH     = 64;
	localparam int PTR_W     = $clog2(DEPTH);
	localparam int FIELD_W   = 5;
	localparam int NUM_SMALL = 4;

	// Field mask bit of the average voltage.
	localparam logic [FIELD_W-1:0] AVG_MASK = FIELD_W'(1);

	// Operation codes.
	localparam logic [2:0] OP_WR_AVG   = 3'd0;
	localparam logic [2:0] OP_WR_FIELD = 3'd1;
	localparam logic [2:0] OP_READ     = 3'd2;
	localparam logic [2:0] OP_LAST_AVG = 3'd3;
	localparam logic [2:0] OP_CLEAR    = 3'd4;

	// Field select codes for a field write.
	localparam logic [2:0] FS_OFFSET     = 3'd1;
	localparam logic [2:0] FS_TEMP_THREE = 3'd4;

	// Status codes.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_OVERFLOW   = 3'd1;
	localparam logic [2:0] ST_INCOMPLETE = 3'd2;
	localparam logic [2:0] ST_INC_OVF    = 3'd3;
	localparam logic [2:0] ST_OVERWRITE  = 3'd4;
	localparam logic [2:0] ST_INVALID    = 3'd5;
	localparam logic [2:0] ST_NOT_FILLED = 3'd6;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CLEAR
	} state_t;

	// Input transaction.
	typedef struct packed {
		logic [2:0]  operation;
		logic [2:0]  field_select;
		logic [63:0] value_bits;
	} item_t;

	// Result transaction.
	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] avg_bits;
		logic [31:0] offset_bits;
		logic [31:0] temp_one_bits;
		logic [31:0] temp_two_bits;
		logic [31:0] temp_three_bits;
	} result_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic issue;
		logic read_out;
		logic sweep;
	} raf_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic sweep_last;
	} raf_stat_t;

endpackage

// File: rtl/record_assembly_ring_fifo.sv
// ----------------------------------------------------------------------------
// Record assembly ring FIFO
// Ring of acquisition records assembled field by field, with APB setup.
//
//   Channel   Handshake                        Payload
//   input     start & !busy                    item   (item_t)
//   result    done, one cycle, no backpressure  result (result_t)
//   config    psel & penable & pwrite          pwdata[4:0] -> required fields
//
// Average and field writes, unknown operations and clear are accepted while idle and show
// the result on the next cycle. Read out and last average pass through the registered read
// port of the record memories and then the result register. Clear and reset both run a
// sweep through every row of the store, one row a cycle, with busy high;
// the clear result appears in the first sweep cycle. Results cannot be stalled.
// ----------------------------------------------------------------------------
`include "record_assembly_ring_fifo_macros.svh"

module record_assembly_ring_fifo import raf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_REQUIRED = 1'b0;

	logic [FIELD_W-1:0] required_q;
	raf_cmd_t           cmd;
	raf_stat_t          stat;
	logic               accept_rd;
	logic               accept_wr;

	// Required field register; the average bit is always set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			required_q <= AVG_MASK;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_REQUIRED) begin
			required_q <= pwdata[FIELD_W-1:0] | AVG_MASK;
		end
	end

	// Register read back.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_REQUIRED) ? {(32 - FIELD_W)'(0), required_q} : '0;

	raf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (item.operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	raf_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.required (required_q),
		.stat     (stat),
		.done     (done),
		.result   (result)
	);

	// Accepted read-type and write-type transactions.
	assign accept_rd = start && !busy &&
	                   (item.operation == OP_READ || item.operation == OP_LAST_AVG);
	assign accept_wr = start && !busy &&
	                   (item.operation == OP_WR_AVG || item.operation == OP_WR_FIELD);

	// A read transaction keeps the block busy and silent in the following cycle.
	`RAF_ASSERT_NEXT(a_read_holds, accept_rd, busy && !done, "read transaction did not hold busy")
	// Every read-out cycle delivers exactly one result next.
	`RAF_ASSERT_NEXT(a_read_done, cmd.read_out, done && !busy, "read-out produced no result")
	// An average or field write shows its result in the next cycle, with the block idle.
	`RAF_ASSERT_NEXT(a_write_done, accept_wr, done && !busy, "write transaction produced no result")
	// Busy always means the controller is sweeping or finishing a read.
	`RAF_ASSERT_NOW(a_busy_work, busy, cmd.sweep || cmd.read_out, "busy without work")

endmodule

// File: rtl/raf_ctrl.sv
// ----------------------------------------------------------------------------
// Record assembly ring FIFO controller
// Sequences transaction issue, the registered memory read and the clear sweep.
// ----------------------------------------------------------------------------
module raf_ctrl import raf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] operation,
	input  raf_stat_t  stat,
	output raf_cmd_t   cmd,
	output logic       busy
);

	state_t state_q;
	state_t state_d;

	// State register; reset begins with a clearing sweep of the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		cmd.issue    = 1'b0;
		cmd.read_out = 1'b0;
		cmd.sweep    = 1'b0;
		busy         = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy      = 1'b0;
				cmd.issue = start;
				if (start) begin
					if (operation == OP_READ || operation == OP_LAST_AVG) begin
						state_d = S_READ;
					end else if (operation == OP_CLEAR) begin
						state_d = S_CLEAR;
					end
				end
			end
			S_READ: begin
				cmd.read_out = 1'b1;
				state_d      = S_IDLE;
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/raf_datapath.sv
// ----------------------------------------------------------------------------
// Record assembly ring FIFO datapath
// Pointers, field mask, record memories, status logic and result register.
// ----------------------------------------------------------------------------
module raf_datapath import raf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  raf_cmd_t           cmd,
	input  item_t              item,
	input  logic [FIELD_W-1:0] required,
	output raf_stat_t          stat,
	output logic               done,
	output result_t            result
);

	// Ring increment and decrement that also hold for a depth that is not a power of two.
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
		prev_ptr = (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
	endfunction

	logic [PTR_W-1:0]   wp_q, rp_q, sweep_idx_q;
	logic [FIELD_W-1:0] fp_q;
	logic [2:0]         op_q;
	logic               done_q;
	result_t            result_q;

	logic [63:0]                 avg_mem [DEPTH];
	logic [NUM_SMALL-1:0][31:0]  small_mem [DEPTH];
	logic [63:0]                 rd_avg_q;
	logic [NUM_SMALL-1:0][31:0]  rd_small_q;

	logic               complete_cur;
	logic [PTR_W-1:0]   wp_inc, wp_a, wp_a_inc, last_idx, avg_rd_addr;
	logic [FIELD_W-1:0] fp_a, fsel_bit;
	logic [2:0]         st_a;
	logic               sel_valid;
	logic               is_read_type;

	logic [PTR_W-1:0]   wp_n, rp_n, avg_wr_addr;
	logic [FIELD_W-1:0] fp_n, fp_w;
	logic [2:0]         st_n;

	logic                 avg_we;
	logic [PTR_W-1:0]     avg_addr, small_addr;
	logic [63:0]          avg_wdata;
	logic [NUM_SMALL-1:0] small_we;
	logic [31:0]          small_wdata;

	// A record that already holds the required set advances before any write.
	assign complete_cur = ((fp_q & required) == required);
	assign wp_inc       = next_ptr(wp_q);
	assign wp_a         = complete_cur ? wp_inc : wp_q;
	assign fp_a         = complete_cur ? '0 : fp_q;
	assign st_a         = (complete_cur && wp_inc == rp_q) ? ST_OVERFLOW : ST_OK;
	assign wp_a_inc     = next_ptr(wp_a);
	assign fsel_bit     = FIELD_W'(1) << item.field_select;
	assign sel_valid    = (item.field_select >= FS_OFFSET) &&
	                      (item.field_select <= FS_TEMP_THREE);
	assign is_read_type = (item.operation == OP_READ) || (item.operation == OP_LAST_AVG);

	// Latest average sits in the previous entry when the current one lacks it.
	assign last_idx    = fp_q[0] ? wp_q : prev_ptr(wp_q);
	assign avg_rd_addr = (item.operation == OP_READ) ? rp_q : last_idx;

	// Next pointers, mask and status for the transaction on the input.
	always_comb begin
		wp_n        = wp_q;
		rp_n        = rp_q;
		fp_n        = fp_q;
		fp_w        = '0;
		st_n        = ST_OK;
		avg_wr_addr = wp_q;
		unique case (item.operation)
			OP_WR_AVG: begin
				if (complete_cur || fp_q[0]) begin
					// Complete record or a repeated average: the value goes to the next entry.
					avg_wr_addr = wp_inc;
					wp_n        = wp_inc;
					fp_n        = AVG_MASK;
					if (complete_cur) begin
						st_n = (wp_inc == rp_q) ? ST_OVERFLOW : ST_OK;
					end else begin
						st_n = (wp_inc == rp_q) ? ST_INC_OVF : ST_INCOMPLETE;
					end
				end else begin
					fp_w = fp_q | AVG_MASK;
					if ((fp_w & required) == required) begin
						wp_n = wp_inc;
						fp_n = '0;
						st_n = (wp_inc == rp_q) ? ST_OVERFLOW : ST_OK;
					end else begin
						fp_n = fp_w;
					end
				end
			end
			OP_WR_FIELD: begin
				wp_n = wp_a;
				fp_n = fp_a;
				if (!sel_valid) begin
					st_n = ST_INVALID;
				end else if ((fp_a & fsel_bit) != '0) begin
					st_n = ST_OVERWRITE;
				end else begin
					fp_w = fp_a | fsel_bit;
					if ((fp_w & required) == required) begin
						wp_n = wp_a_inc;
						fp_n = '0;
						st_n = (wp_a_inc == rp_q) ? ST_OVERFLOW : ST_OK;
					end else begin
						fp_n = fp_w;
						st_n = st_a;
					end
				end
			end
			OP_READ: begin
				if (wp_q == rp_q) begin
					st_n = ST_NOT_FILLED;
				end else begin
					rp_n = next_ptr(rp_q);
				end
			end
			OP_LAST_AVG: begin
				st_n = ST_OK;
			end
			OP_CLEAR: begin
				wp_n = '0;
				rp_n = '0;
				fp_n = '0;
			end
			default: begin
				st_n = ST_OK;
			end
		endcase
	end

	// Pointer, mask, sweep counter and latched operation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			fp_q        <= '0;
			sweep_idx_q <= '0;
			op_q        <= OP_WR_AVG;
		end else begin
			if (cmd.issue) begin
				wp_q <= wp_n;
				rp_q <= rp_n;
				fp_q <= fp_n;
				op_q <= item.operation;
				if (item.operation == OP_CLEAR) begin
					sweep_idx_q <= '0;
				end
			end
			if (cmd.sweep) begin
				sweep_idx_q <= next_ptr(sweep_idx_q);
			end
		end
	end

	assign stat.sweep_last = (sweep_idx_q == PTR_W'(DEPTH - 1));

	// Memory write ports; the clearing sweep writes zero one row a cycle.
	always_comb begin
		avg_we      = cmd.sweep || (cmd.issue && item.operation == OP_WR_AVG);
		avg_addr    = cmd.sweep ? sweep_idx_q : avg_wr_addr;
		avg_wdata   = cmd.sweep ? '0 : item.value_bits;
		small_addr  = cmd.sweep ? sweep_idx_q : wp_a;
		small_wdata = cmd.sweep ? '0 : item.value_bits[31:0];
		for (int k = 0; k < NUM_SMALL; k++) begin
			small_we[k] = cmd.sweep ||
			              (cmd.issue && item.operation == OP_WR_FIELD && sel_valid &&
			               item.field_select == 3'(k + 1));
		end
	end

	// Average memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (avg_we) begin
			avg_mem[avg_addr] <= avg_wdata;
		end
		rd_avg_q <= avg_mem[avg_rd_addr];
	end

	// Offset and temperature memory with one write enable per lane.
	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_SMALL; k++) begin
			if (small_we[k]) begin
				small_mem[small_addr][k] <= small_wdata;
			end
		end
		rd_small_q <= small_mem[rp_q];
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.issue && !is_read_type) || cmd.read_out;
		end
	end

	// Result payload; status is latched on issue, read data from the memory read registers on read out.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			result_q.status          <= st_n;
			result_q.avg_bits        <= '0;
			result_q.offset_bits     <= '0;
			result_q.temp_one_bits   <= '0;
			result_q.temp_two_bits   <= '0;
			result_q.temp_three_bits <= '0;
		end else if (cmd.read_out) begin
			result_q.avg_bits <= rd_avg_q;
			if (op_q == OP_READ) begin
				result_q.offset_bits     <= rd_small_q[0];
				result_q.temp_one_bits   <= rd_small_q[1];
				result_q.temp_two_bits   <= rd_small_q[2];
				result_q.temp_three_bits <= rd_small_q[3];
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
